>>> rtl/core/als_pkg.sv
package als_pkg;

  // Field widths
  localparam int unsigned TimeW   = 10;
  localparam int unsigned CostW   = 18;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned MaxStationsDef = 64;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENTRY_A = 2'd0,
    CFG_ENTRY_B = 2'd1,
    CFG_EXIT_A  = 2'd2,
    CFG_EXIT_B  = 2'd3
  } cfg_reg_e;

  // Microprogram addresses
  typedef enum logic [1:0] {
    STEP_ACCEPT = 2'd0,
    STEP_FINISH = 2'd1,
    STEP_EMIT   = 2'd2
  } step_e;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_ALWAYS   = 2'd1,
    COND_IN_DONE  = 2'd2,
    COND_OUT_DONE = 2'd3
  } cond_e;

  // One control word
  typedef struct packed {
    logic  in_rdy;
    logic  finish_en;
    logic  emit_en;
    cond_e cond;
    step_e target;
    step_e seq_next;
  } ctrl_t;

  // Datapath status toward the sequencer
  typedef struct packed {
    logic in_done;
    logic out_done;
  } status_t;

  // Control store
  function automatic ctrl_t ucode_rom(step_e step);
    ctrl_t w;
    w = '{in_rdy: 1'b0, finish_en: 1'b0, emit_en: 1'b0, cond: COND_NONE,
          target: STEP_ACCEPT, seq_next: STEP_ACCEPT};
    unique case (step)
      STEP_ACCEPT: begin
        w.in_rdy   = 1'b1;
        w.cond     = COND_IN_DONE;
        w.target   = STEP_FINISH;
        w.seq_next = STEP_ACCEPT;
      end
      STEP_FINISH: begin
        w.finish_en = 1'b1;
        w.cond      = COND_ALWAYS;
        w.target    = STEP_EMIT;
        w.seq_next  = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit_en  = 1'b1;
        w.cond     = COND_OUT_DONE;
        w.target   = STEP_ACCEPT;
        w.seq_next = STEP_EMIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_ACCEPT;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/als_seq.sv
module als_seq
  import als_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  step_e step_q, step_d;
  logic  take_jump;

  // Fetch the control word of the current step
  assign ctrl_o = ucode_rom(step_q);

  // Evaluate the jump condition
  always_comb begin
    unique case (ctrl_o.cond)
      COND_NONE:     take_jump = 1'b0;
      COND_ALWAYS:   take_jump = 1'b1;
      COND_IN_DONE:  take_jump = status_i.in_done;
      COND_OUT_DONE: take_jump = status_i.out_done;
      default:       take_jump = 1'b0;
    endcase
  end

  assign step_d = take_jump ? ctrl_o.target : ctrl_o.seq_next;

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_ACCEPT;
    end else begin
      step_q <= step_d;
    end
  end

  a_finish_after_last_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.in_done |=> ctrl_o.finish_en)
    else $error("finish step did not follow the last station");

  a_accept_after_last_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.out_done |=> ctrl_o.in_rdy)
    else $error("sequencer did not return to accepting stations");

  a_one_action : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_o.in_rdy, ctrl_o.finish_en, ctrl_o.emit_en}))
    else $error("control word enables more than one action");

endmodule

>>> rtl/core/als_dp.sv
module als_dp
  import als_pkg::*;
#(
  parameter int unsigned MaxStations = MaxStationsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output status_t            status_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [TimeW-1:0]   time_a_i,
  input  logic [TimeW-1:0]   time_b_i,
  input  logic [TimeW-1:0]   move_a_to_b_i,
  input  logic [TimeW-1:0]   move_b_to_a_i,
  input  logic               final_station_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IdxW-1:0]    station_index_o,
  output logic               line_used_o,
  output logic [CostW-1:0]   total_time_o,
  output logic               path_end_o
);

  localparam int unsigned CntW  = $clog2(MaxStations + 1);
  localparam int unsigned AddrW = $clog2(MaxStations);

  logic [TimeW-1:0] entry_a_q, entry_b_q, exit_a_q, exit_b_q;
  logic [CostW-1:0] best_a_q, best_b_q;
  logic [TimeW-1:0] move_ab_q, move_ba_q;
  logic [CntW-1:0]  cnt_q, cnt_inc;
  logic [CntW-1:0]  k_q, k_d;
  logic             line_q, line_d;
  logic [CostW-1:0] total_q;
  logic [1:0]       choice_mem [MaxStations];
  logic [1:0]       rd_q;
  logic [AddrW-1:0] rd_addr;

  logic             in_fire, first, full, emit_fire, out_free;
  logic [CostW-1:0] stay_a, cross_a, stay_b, cross_b, na, nb;
  logic [1:0]       choice;
  logic [CostW-1:0] fin_a, fin_b;

  logic             out_valid_q;
  logic [CntW-1:0]  out_k_q;
  logic             out_line_q, out_end_q;
  logic [CostW-1:0] out_total_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_a_q <= '0;
      entry_b_q <= '0;
      exit_a_q  <= '0;
      exit_b_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ENTRY_A: entry_a_q <= cfg_data_i;
        CFG_ENTRY_B: entry_b_q <= cfg_data_i;
        CFG_EXIT_A:  exit_a_q  <= cfg_data_i;
        CFG_EXIT_B:  exit_b_q  <= cfg_data_i;
        default:     entry_a_q <= entry_a_q;
      endcase
    end
  end

  // Forward relaxation of one station
  assign in_stall_o = !ctrl_i.in_rdy;
  assign in_fire    = in_valid_i && ctrl_i.in_rdy;
  assign first      = (cnt_q == '0);
  assign cnt_inc    = cnt_q + 1'b1;
  assign full       = (cnt_inc == CntW'(MaxStations));

  assign stay_a  = best_a_q + CostW'(time_a_i);
  assign cross_a = best_b_q + CostW'(move_ba_q) + CostW'(time_a_i);
  assign stay_b  = best_b_q + CostW'(time_b_i);
  assign cross_b = best_a_q + CostW'(move_ab_q) + CostW'(time_b_i);

  always_comb begin
    choice = 2'b00;
    if (first) begin
      na = CostW'(entry_a_q) + CostW'(time_a_i);
      nb = CostW'(entry_b_q) + CostW'(time_b_i);
    end else begin
      // ties stay on the same line
      if (stay_a <= cross_a) begin
        na = stay_a;
      end else begin
        na        = cross_a;
        choice[0] = 1'b1;
      end
      if (stay_b <= cross_b) begin
        nb = stay_b;
      end else begin
        nb        = cross_b;
        choice[1] = 1'b1;
      end
    end
  end

  // Exit costs, ties go to line A
  assign fin_a = best_a_q + CostW'(exit_a_q);
  assign fin_b = best_b_q + CostW'(exit_b_q);

  // Backtrace control
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_fire = ctrl_i.emit_en && out_free;

  assign status_o.in_done  = in_fire && (final_station_i || full);
  assign status_o.out_done = emit_fire && (k_q == CntW'(1));

  always_comb begin
    k_d    = k_q;
    line_d = line_q;
    if (ctrl_i.finish_en) begin
      k_d    = cnt_q;
      line_d = (fin_a <= fin_b) ? 1'b0 : 1'b1;
    end else if (emit_fire) begin
      k_d    = k_q - 1'b1;
      line_d = line_q ^ rd_q[line_q];
    end
  end

  assign rd_addr = AddrW'(k_d - 1'b1);

  // Run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_a_q  <= '0;
      best_b_q  <= '0;
      move_ab_q <= '0;
      move_ba_q <= '0;
      cnt_q     <= '0;
    end else if (in_fire) begin
      best_a_q  <= na;
      best_b_q  <= nb;
      move_ab_q <= move_a_to_b_i;
      move_ba_q <= move_b_to_a_i;
      cnt_q     <= cnt_inc;
    end else if (status_o.out_done) begin
      cnt_q <= '0;
    end
  end

  // Backtrace registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      line_q <= 1'b0;
    end else begin
      k_q    <= k_d;
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish_en) begin
      total_q <= (fin_a <= fin_b) ? fin_a : fin_b;
    end
  end

  // Choice store, registered read one step ahead of the backtrace
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      choice_mem[cnt_q[AddrW-1:0]] <= choice;
    end
    rd_q <= choice_mem[rd_addr];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_k_q     <= k_q;
      out_line_q  <= line_q;
      out_total_q <= total_q;
      out_end_q   <= (k_q == CntW'(1));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign station_index_o = IdxW'(out_k_q);
  assign line_used_o     = out_line_q;
  assign total_time_o    = out_total_q;
  assign path_end_o      = out_end_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxStations))
    else $error("station count beyond store depth");

  a_emit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit_en |-> (k_q != '0))
    else $error("backtrace ran past station one");

endmodule

>>> rtl/core/assembly_line_schedule.sv
// Stations are taken one per cycle while the block is collecting a run.
// After the last station, a finish step adds exit costs, then one result per
// cycle from the last station back to station one, paced by the output stall.
// Input is held stalled during the finish step and the backtrace.
// Reset (rst_ni low, asynchronous) clears control state and the run; the choice
// store needs no clearing since a backtrace reads only entries of its run.
module assembly_line_schedule
  import als_pkg::*;
#(
  parameter int unsigned MaxStations = MaxStationsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [TimeW-1:0]   time_a_i,
  input  logic [TimeW-1:0]   time_b_i,
  input  logic [TimeW-1:0]   move_a_to_b_i,
  input  logic [TimeW-1:0]   move_b_to_a_i,
  input  logic               final_station_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IdxW-1:0]    station_index_o,
  output logic               line_used_o,
  output logic [CostW-1:0]   total_time_o,
  output logic               path_end_o
);

  ctrl_t   ctrl;
  status_t status;

  als_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  als_dp #(
    .MaxStations (MaxStations)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .time_a_i        (time_a_i),
    .time_b_i        (time_b_i),
    .move_a_to_b_i   (move_a_to_b_i),
    .move_b_to_a_i   (move_b_to_a_i),
    .final_station_i (final_station_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .station_index_o (station_index_o),
    .line_used_o     (line_used_o),
    .total_time_o    (total_time_o),
    .path_end_o      (path_end_o)
  );

endmodule
